// ----- rtl/sfla_pkg.sv -----
// Shared constants for the section free-list allocator: codes, widths and defaults.
package sfla_pkg;

    // Field and register widths
    localparam int ADDR_W = 32;
    localparam int OP_W   = 2;
    localparam int RC_W   = 2;
    localparam int SST_W  = 2;
    localparam int CFG_W  = 10;
    localparam int CFG_IDX_W = 1;

    // Default sizing
    localparam int MAX_SECTIONS_DEF      = 512;
    localparam int SECTION_SIZE_LOG2_DEF = 20;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    // Section states
    localparam logic [SST_W-1:0] SEC_FREE     = 2'd0;
    localparam logic [SST_W-1:0] SEC_INUSE    = 2'd1;
    localparam logic [SST_W-1:0] SEC_RESERVED = 2'd2;

    // Status codes
    localparam logic [RC_W-1:0] RC_OK       = 2'd0;
    localparam logic [RC_W-1:0] RC_NOMEM    = 2'd1;
    localparam logic [RC_W-1:0] RC_BADPARAM = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SECTIONS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE     = 1'd1;
    localparam logic [CFG_W-1:0] TOTAL_SECTIONS_RST = 10'd480;
    localparam logic [CFG_W-1:0] FIRST_FREE_RST     = 10'd0;

endpackage

// ----- rtl/section_free_list_allocator_top.sv -----
// Section free-list allocator: state memory, LIFO free stack and command sequencer.
//
// Usage: raise start with operation/address while busy is low; the item is taken
// at that edge. Exactly one result follows, shown on status_code and
// section_address for a single cycle with done high; the receiver must take it
// then, it cannot stall the block. An allocate on an empty list, a rejected free
// and an unknown operation are answered straight from decode; a successful-path
// allocate or a range-checked free does one read of the stack or section-state
// memory, then the write back; initialize runs a sweep over the MAX_SECTIONS
// entries that writes one section-state entry and makes at most one stack push
// per cycle, then the result. busy is high from the accepting edge until the
// result is on the ports, so the next item can be taken at the edge that ends
// the result cycle. Before the first initialize no section is in use, so every
// free is rejected and allocate reports out of memory.
// Configuration writes (cfg_we) take effect at once and belong in idle time.
module section_free_list_allocator_top
    import sfla_pkg::*;
#(
    parameter int MAX_SECTIONS      = MAX_SECTIONS_DEF,
    parameter int SECTION_SIZE_LOG2 = SECTION_SIZE_LOG2_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [ADDR_W-1:0]    address,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [RC_W-1:0]      status_code,
    output logic [ADDR_W-1:0]    section_address
);

    localparam int IDX_W = $clog2(MAX_SECTIONS);
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int SEC_W = ADDR_W - SECTION_SIZE_LOG2;
    localparam int CW    = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int CMP_W = (SEC_W > CW) ? SEC_W : CW;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_FREE  = 2'd2;
    localparam logic [1:0] S_INIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] iter_reg, iter_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             init_reg, init_next;
    logic             done_reg, done_next;
    logic [RC_W-1:0]  status_reg, status_next;
    logic [ADDR_W-1:0] saddr_reg, saddr_next;
    logic [CFG_W-1:0] total_reg;
    logic [CFG_W-1:0] first_reg;

    // Memories and their ports
    logic [SST_W-1:0] state_mem [MAX_SECTIONS];
    logic [IDX_W-1:0] stack_mem [MAX_SECTIONS];
    logic             st_we, st_re;
    logic [IDX_W-1:0] st_waddr, st_raddr;
    logic [SST_W-1:0] st_wdata;
    logic [SST_W-1:0] st_rdata_reg;
    logic             sk_we, sk_re;
    logic [IDX_W-1:0] sk_waddr, sk_raddr;
    logic [IDX_W-1:0] sk_wdata;
    logic [IDX_W-1:0] sk_rdata_reg;

    // Derived values
    logic [CW-1:0]     live_ext;
    logic [CNT_W-1:0]  pop_cnt;
    logic [CMP_W-1:0]  req_sec;
    logic [IDX_W-1:0]  req_idx;
    logic              free_ok;
    logic              count_full;
    logic              iter_free;
    logic [ADDR_W+IDX_W-1:0] alloc_wide;

    // Cap the section count at the memory depth
    always_comb
    begin
        if (CW'(total_reg) > CW'(MAX_SECTIONS))
            live_ext = CW'(MAX_SECTIONS);
        else
            live_ext = CW'(total_reg);
    end

    assign pop_cnt    = count_reg - CNT_W'(1);
    assign req_sec    = CMP_W'(address[ADDR_W-1:SECTION_SIZE_LOG2]);
    assign req_idx    = req_sec[IDX_W-1:0];
    assign free_ok    = (address[SECTION_SIZE_LOG2-1:0] == '0) &&
                        (req_sec < CMP_W'(live_ext));
    assign count_full = (count_reg == CNT_W'(MAX_SECTIONS));
    assign iter_free  = !(CW'(iter_reg) < CW'(first_reg)) && (CW'(iter_reg) < live_ext);
    assign alloc_wide = {{ADDR_W{1'b0}}, sk_rdata_reg} << SECTION_SIZE_LOG2;

    // Sequence one item: decode, read, write back, report
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        iter_next   = iter_reg;
        idx_next    = idx_reg;
        init_next   = init_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        saddr_next  = saddr_reg;
        st_we    = 1'b0;
        st_re    = 1'b0;
        st_waddr = iter_reg;
        st_raddr = req_idx;
        st_wdata = SEC_RESERVED;
        sk_we    = 1'b0;
        sk_re    = 1'b0;
        sk_waddr = count_reg[IDX_W-1:0];
        sk_raddr = pop_cnt[IDX_W-1:0];
        sk_wdata = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = RC_NOMEM;
                                saddr_next  = '0;
                            end
                            else
                            begin
                                sk_re      = 1'b1;
                                state_next = S_ALLOC;
                            end
                        end
                        OP_FREE:
                        begin
                            if (free_ok)
                            begin
                                st_re      = 1'b1;
                                idx_next   = req_idx;
                                state_next = S_FREE;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = RC_BADPARAM;
                                saddr_next  = '0;
                            end
                        end
                        OP_INIT:
                        begin
                            count_next = '0;
                            iter_next  = '0;
                            init_next  = 1'b1;
                            state_next = S_INIT;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = RC_BADPARAM;
                            saddr_next  = '0;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                // Mark the popped section in use and return its address
                st_we       = 1'b1;
                st_waddr    = sk_rdata_reg;
                st_wdata    = SEC_INUSE;
                count_next  = pop_cnt;
                done_next   = 1'b1;
                status_next = RC_OK;
                saddr_next  = alloc_wide[ADDR_W-1:0];
                state_next  = S_IDLE;
            end
            S_FREE:
            begin
                // Release only a section that is in use
                done_next  = 1'b1;
                saddr_next = '0;
                state_next = S_IDLE;
                if (init_reg && (st_rdata_reg == SEC_INUSE))
                begin
                    st_we       = 1'b1;
                    st_waddr    = idx_reg;
                    st_wdata    = SEC_FREE;
                    status_next = RC_OK;
                    if (!count_full)
                    begin
                        sk_we      = 1'b1;
                        sk_wdata   = idx_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    status_next = RC_BADPARAM;
                end
            end
            S_INIT:
            begin
                // Sweep one section per cycle, pushing free ones in ascending order
                st_we    = 1'b1;
                st_waddr = iter_reg;
                st_wdata = iter_free ? SEC_FREE : SEC_RESERVED;
                if (iter_free && !count_full)
                begin
                    sk_we      = 1'b1;
                    sk_wdata   = iter_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                if (iter_reg == IDX_W'(MAX_SECTIONS - 1))
                begin
                    done_next   = 1'b1;
                    status_next = RC_OK;
                    saddr_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    iter_next = iter_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            iter_reg   <= '0;
            init_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= RC_OK;
            saddr_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            iter_reg   <= iter_next;
            init_reg   <= init_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            saddr_reg  <= saddr_next;
        end
    end

    // Hold the index of the section being freed
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_SECTIONS_RST;
            first_reg <= FIRST_FREE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOTAL_SECTIONS: total_reg <= cfg_data;
                CFG_FIRST_FREE:     first_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Section-state memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
            state_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_rdata_reg <= state_mem[st_raddr];
    end

    // Free-stack memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (sk_we)
            stack_mem[sk_waddr] <= sk_wdata;
        if (sk_re)
            sk_rdata_reg <= stack_mem[sk_raddr];
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status_code     = status_reg;
    assign section_address = saddr_reg;

endmodule

// ----- test/section_free_list_allocator_top_tb.sv -----
// Self-checking testbench for the section free-list allocator: command driver, reply monitor and allocator model.
module section_free_list_allocator_top_tb;
    import sfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SECTIONS  = MAX_SECTIONS_DEF;
    localparam int SIZE_LOG2 = SECTION_SIZE_LOG2_DEF;
    // Operation code the block does not define; it must be rejected
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [RC_W-1:0]   rc;
        logic [ADDR_W-1:0] sa;
    } reply_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      operation = OP_ALLOC;
    logic [ADDR_W-1:0]    address = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TOTAL_SECTIONS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 done;
    logic [RC_W-1:0]      status_code;
    logic [ADDR_W-1:0]    section_address;

    // Allocator model: section states, LIFO of free indices and register copies
    logic [SST_W-1:0] model_state [0:SECTIONS-1];
    logic [8:0]       model_stack [0:SECTIONS-1];
    int unsigned      model_depth = 0;
    logic [CFG_W-1:0] model_total = TOTAL_SECTIONS_RST;
    logic [CFG_W-1:0] model_first = FIRST_FREE_RST;

    cmd_t   cmd_backlog [$];
    reply_t owed_replies [$];
    logic   took = 1'b0;
    int     idle_pct = 0;
    int     mismatches = 0;

    section_free_list_allocator_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .address         (address),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status_code     (status_code),
        .section_address (section_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Put a section back on the free list, never past its capacity
    function automatic void push_free(input int unsigned idx);
        if (model_depth < SECTIONS)
        begin
            model_stack[model_depth] = idx[8:0];
            model_depth++;
        end
    endfunction

    // Apply one command to the model and return the reply it must produce
    function automatic reply_t predict_reply(input logic [OP_W-1:0] op,
                                             input logic [ADDR_W-1:0] addr);
        reply_t      r;
        int unsigned live;
        int unsigned idx;
        logic [63:0] limit;
        r.rc = RC_BADPARAM;
        r.sa = '0;
        live = (model_total > SECTIONS) ? SECTIONS : model_total;
        case (op)
            OP_ALLOC:
            begin
                if (model_depth == 0)
                    r.rc = RC_NOMEM;
                else
                begin
                    model_depth--;
                    idx = 32'(model_stack[model_depth]);
                    model_state[idx] = SEC_INUSE;
                    r.sa = idx << SIZE_LOG2;
                    r.rc = RC_OK;
                end
            end
            OP_FREE:
            begin
                limit = 64'(live) << SIZE_LOG2;
                if (addr[SIZE_LOG2-1:0] == '0 && 64'(addr) < limit)
                begin
                    idx = addr >> SIZE_LOG2;
                    if (idx < SECTIONS && model_state[idx] == SEC_INUSE)
                    begin
                        model_state[idx] = SEC_FREE;
                        push_free(idx);
                        r.rc = RC_OK;
                    end
                end
            end
            OP_INIT:
            begin
                model_depth = 0;
                for (int unsigned i = 0; i < SECTIONS; i++)
                begin
                    if (i < model_first || i >= live)
                        model_state[i] = SEC_RESERVED;
                    else
                    begin
                        model_state[i] = SEC_FREE;
                        push_free(i);
                    end
                end
                r.rc = RC_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Find a section currently in use, starting at a random place; -1 if none
    function automatic int find_busy_section();
        int unsigned base;
        int unsigned j;
        base = $urandom_range(SECTIONS - 1);
        for (int unsigned k = 0; k < SECTIONS; k++)
        begin
            j = (base + k) % SECTIONS;
            if (model_state[j] == SEC_INUSE)
                return j;
        end
        return -1;
    endfunction

    // Build one random command: mostly allocs and frees of live sections, some noise
    function automatic cmd_t next_cmd();
        cmd_t        c;
        int unsigned pick;
        int          sec;
        pick   = $urandom_range(99);
        c.addr = $urandom;
        if (pick < 42)
            c.op = OP_ALLOC;
        else if (pick < 94)
        begin
            c.op = OP_FREE;
            sec  = find_busy_section();
            pick = $urandom_range(9);
            if (sec < 0)
                sec = $urandom_range(2 * SECTIONS - 1);
            if (pick < 7)
                c.addr = sec << SIZE_LOG2;
            else if (pick == 7)
                c.addr = $urandom_range(2 * SECTIONS - 1) << SIZE_LOG2;
            else if (pick == 8)
                c.addr = (sec << SIZE_LOG2) | (32'd1 << $urandom_range(SIZE_LOG2 - 1, 0));
        end
        else if (pick < 97)
            c.op = OP_INIT;
        else
            c.op = OP_UNDEFINED;
        return c;
    endfunction

    // Driver: hold a command until it is taken, then present the next or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took)
            ;
        else if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            operation <= cmd_backlog[0].op;
            address   <= cmd_backlog[0].addr;
            start     <= 1'b1;
            void'(cmd_backlog.pop_front());
        end
        else
            start <= 1'b0;
    end

    // Monitor: track register writes, predict each transfer, check each reply
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOTAL_SECTIONS)
                    model_total = cfg_data;
                else if (cfg_index == CFG_FIRST_FREE)
                    model_first = cfg_data;
            end
            if (start && !busy)
                owed_replies.push_back(predict_reply(operation, address));
            if (done)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("reply with none owed: status_code %0d section_address %h",
                           status_code, section_address);
                    mismatches++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (status_code !== want.rc)
                    begin
                        $error("status_code: expected %0d, got %0d", want.rc, status_code);
                        mismatches++;
                    end
                    if (section_address !== want.sa)
                    begin
                        $error("section_address: expected %h, got %h",
                               want.sa, section_address);
                        mismatches++;
                    end
                end
            end
        end
        took <= start && !busy;
    end

    // Wait until every command is taken and every reply has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() > 0 || start || busy || owed_replies.size() > 0);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] first);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOTAL_SECTIONS;
        cfg_data  <= total;
        @(negedge clk);
        cfg_index <= CFG_FIRST_FREE;
        cfg_data  <= first;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        cmd_t c;
        c.op   = op;
        c.addr = addr;
        cmd_backlog.push_back(c);
    endtask

    // One phase: drain, reprogram, optionally rebuild the list, then random traffic
    task automatic run_phase(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] first,
                             input int idle, input int count, input bit rebuild);
        wait_drained();
        write_regs(total, first);
        idle_pct = idle;
        if (rebuild)
            queue_cmd(OP_INIT, $urandom);
        for (int i = 0; i < count; i++)
        begin
            while (cmd_backlog.size() >= 2)
                @(negedge clk);
            cmd_backlog.push_back(next_cmd());
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] total;
        logic [CFG_W-1:0] first;
        int               idles [4];
        idles = '{0, 64, 16, 0};
        for (int i = 0; i < SECTIONS; i++)
            model_state[i] = SEC_RESERVED;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Before any initialize: empty list, nothing in use
        queue_cmd(OP_ALLOC, 32'hFFFF_FFFF);
        queue_cmd(OP_FREE, 32'h0);
        queue_cmd(OP_UNDEFINED, 32'h0);
        wait_drained();

        // Four sections, first reserved: exhaust, recycle and reject bad frees
        write_regs(10'd4, 10'd1);
        queue_cmd(OP_INIT, 32'h0);
        queue_cmd(OP_ALLOC, 32'h0);
        queue_cmd(OP_ALLOC, 32'h0);
        queue_cmd(OP_ALLOC, 32'h0);
        queue_cmd(OP_ALLOC, 32'h0);
        queue_cmd(OP_FREE, 32'd2 << SIZE_LOG2);
        queue_cmd(OP_FREE, 32'd2 << SIZE_LOG2);
        queue_cmd(OP_FREE, (32'd3 << SIZE_LOG2) + 32'd1);
        queue_cmd(OP_FREE, 32'h0);
        queue_cmd(OP_FREE, 32'd4 << SIZE_LOG2);
        queue_cmd(OP_FREE, 32'hFFFF_FFFF);
        queue_cmd(OP_FREE, 32'h8000_0000);
        queue_cmd(OP_ALLOC, 32'h0);
        queue_cmd(OP_FREE, 32'd3 << SIZE_LOG2);

        // Fixed corners: reset size, oversize, boundary at and past the end, no sections
        run_phase(10'd480, 10'd0, 0, 220, 1'b1);
        run_phase(10'd1023, 10'd0, 64, 200, 1'b1);
        run_phase(10'd512, 10'd511, 16, 120, 1'b1);
        run_phase(10'd0, 10'd0, 0, 80, 1'b1);
        run_phase(10'd1, 10'd0, 64, 80, 1'b1);
        run_phase(10'd20, 10'd1023, 16, 60, 1'b1);
        run_phase(10'd12, 10'd12, 0, 40, 1'b1);
        run_phase(10'd40, 10'd3, 64, 150, 1'b1);
        // Shrink the range without rebuilding: frees above it must be rejected
        run_phase(10'd10, 10'd3, 0, 100, 1'b0);

        // Random settings, biased toward small section counts
        for (int p = 0; p < 6; p++)
        begin
            if ($urandom_range(1))
                total = CFG_W'($urandom_range(64, 1));
            else
                total = CFG_W'($urandom_range(1023));
            first = CFG_W'($urandom_range(int'(total) + 4));
            run_phase(total, first, idles[p % 4], 100, p != 3);
        end

        wait_drained();
        repeat (SECTIONS + 8) @(negedge clk);
        if (mismatches == 0 && owed_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
